// File: rtl/assert_macros.svh
// Assertion macros used by the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dnle_pkg.sv
`timescale 1ns / 1ps

package dnle_pkg;

    localparam int NAME_MAX  = 255;
    localparam int LABEL_MAX = 62;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = $clog2(LABEL_MAX + 1);
    localparam int NAME_W    = $clog2(NAME_MAX + 1);

    localparam logic [BYTE_W-1:0] DOT_CHAR    = 8'd46;
    localparam logic [LEN_W-1:0]  LABEL_MAX_L = LEN_W'(LABEL_MAX);
    localparam logic [NAME_W-1:0] NAME_MAX_L  = NAME_W'(NAME_MAX);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_READ,
        S_LOAD,
        S_TERM
    } state_t;

endpackage

// File: rtl/dns_name_label_encoder.sv
`timescale 1ns / 1ps
// Streams a dotted hostname in, one character per transaction, and streams
// out its DNS wire form: a length byte and the bytes of each non-empty label,
// then a zero terminator.
// Input channel s_axis: tdata carries the character, tlast marks the end of
// the name (the character of that transaction is ignored).
// Output channel m_axis: tdata carries the encoded byte, tlast marks the zero
// terminator, tuser flags a length byte whose label lost characters.
// An ordinary character is written into the label RAM while the label and
// the name have room. A dot with a pending label, while the name has room,
// or the end mark starts a flush: the length byte is loaded into the output
// register, then each stored character is read from the label RAM and then
// loaded into the output register; after the end mark the terminator
// follows. s_axis_tready stays low for the whole flush; an end mark with no
// pending label goes straight to the terminator.
// A stalled receiver holds the output register, and the flush waits on it.
// Reset clears counters, state flags and output valid, leaving the block
// ready; the label RAM is not cleared, since only written entries are read.
`include "assert_macros.svh"

module dns_name_label_encoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // is_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,   // is_last
    output logic [0:0] m_axis_tuser    // [0] truncated
);

    dnle_pkg::state_t state_reg, state_next;

    logic [dnle_pkg::LEN_W-1:0]  label_len_reg, label_len_next;
    logic [dnle_pkg::LEN_W-1:0]  idx_reg, idx_next;
    logic [dnle_pkg::NAME_W-1:0] name_len_reg, name_len_next;
    logic                        ovf_reg, ovf_next;
    logic                        end_pend_reg, end_pend_next;

    logic                        out_valid_reg, out_valid_next;
    logic [dnle_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_trunc_reg, out_trunc_next;

    logic                        out_free;
    logic                        in_fire;
    logic                        ram_we;
    logic                        ram_re;
    logic [dnle_pkg::BYTE_W-1:0] ram_rdata;

    dnle_ram #(
        .WIDTH (dnle_pkg::BYTE_W),
        .DEPTH (dnle_pkg::LABEL_MAX)
    ) u_label_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (label_len_reg),
        .wdata (s_axis_tdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == dnle_pkg::S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_byte_reg;
    assign m_axis_tlast    = out_last_reg;
    assign m_axis_tuser[0] = out_trunc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dnle_pkg::S_IDLE;
            label_len_reg <= '0;
            idx_reg       <= '0;
            name_len_reg  <= '0;
            ovf_reg       <= 1'b0;
            end_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            label_len_reg <= label_len_next;
            idx_reg       <= idx_next;
            name_len_reg  <= name_len_next;
            ovf_reg       <= ovf_next;
            end_pend_reg  <= end_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_trunc_reg <= out_trunc_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        label_len_next = label_len_reg;
        idx_next       = idx_reg;
        name_len_next  = name_len_reg;
        ovf_next       = ovf_reg;
        end_pend_next  = end_pend_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_trunc_next = out_trunc_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        unique case (state_reg)
            dnle_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    priority if (s_axis_tlast)
                    begin
                        name_len_next = '0;
                        end_pend_next = 1'b1;
                        if (label_len_reg != '0)
                        begin
                            state_next = dnle_pkg::S_LEN;
                        end
                        else
                        begin
                            ovf_next   = 1'b0;
                            state_next = dnle_pkg::S_TERM;
                        end
                    end
                    else if (name_len_reg >= dnle_pkg::NAME_MAX_L)
                    begin
                        if (s_axis_tdata != dnle_pkg::DOT_CHAR)
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else
                    begin
                        name_len_next = name_len_reg + 1'b1;
                        if (s_axis_tdata == dnle_pkg::DOT_CHAR)
                        begin
                            if (label_len_reg != '0)
                            begin
                                end_pend_next = 1'b0;
                                state_next    = dnle_pkg::S_LEN;
                            end
                        end
                        else if (label_len_reg < dnle_pkg::LABEL_MAX_L)
                        begin
                            ram_we         = 1'b1;
                            label_len_next = label_len_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                end
            end

            dnle_pkg::S_LEN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = dnle_pkg::BYTE_W'(label_len_reg);
                    out_last_next  = 1'b0;
                    out_trunc_next = ovf_reg;
                    idx_next       = '0;
                    state_next     = dnle_pkg::S_READ;
                end
            end

            dnle_pkg::S_READ:
            begin
                ram_re     = 1'b1;
                state_next = dnle_pkg::S_LOAD;
            end

            dnle_pkg::S_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = ram_rdata;
                    out_last_next  = 1'b0;
                    out_trunc_next = 1'b0;
                    idx_next       = idx_reg + 1'b1;
                    if (idx_next == label_len_reg)
                    begin
                        label_len_next = '0;
                        ovf_next       = 1'b0;
                        state_next     = end_pend_reg ? dnle_pkg::S_TERM : dnle_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = dnle_pkg::S_READ;
                    end
                end
            end

            dnle_pkg::S_TERM:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = '0;
                    out_last_next  = 1'b1;
                    out_trunc_next = 1'b0;
                    end_pend_next  = 1'b0;
                    state_next     = dnle_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = dnle_pkg::S_IDLE;
            end
        endcase
    end

    `ASSERT_IMPLY(a_label_len_max, clk, rst_n, 1'b1,
                  label_len_reg <= dnle_pkg::LABEL_MAX_L,
                  "Label length exceeds the label limit.")

    `ASSERT_IMPLY(a_flush_nonempty, clk, rst_n, state_reg == dnle_pkg::S_LEN,
                  label_len_reg != '0,
                  "Flush started on an empty label.")

    `ASSERT_IMPLY(a_term_clean, clk, rst_n, m_axis_tvalid && m_axis_tlast,
                  m_axis_tdata == '0 && !m_axis_tuser[0],
                  "Terminator carries data or a truncation flag.")

    `ASSERT_NEXT(a_read_then_load, clk, rst_n, state_reg == dnle_pkg::S_READ,
                 state_reg == dnle_pkg::S_LOAD,
                 "RAM read not followed by the load step.")

endmodule

// File: rtl/dnle_ram.sv
`timescale 1ns / 1ps

module dnle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 62
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: tb/dns_name_label_checker.sv
`timescale 1ns / 1ps

module dns_name_label_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       s_axis_tlast,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    input  logic       m_axis_tlast,
    input  logic [0:0] m_axis_tuser,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [dnle_pkg::BYTE_W-1:0] out_byte;
        logic                        is_last;
        logic                        truncated;
    } wire_byte_t;

    wire_byte_t                  wire_due[$];
    logic [dnle_pkg::BYTE_W-1:0] label_buf [dnle_pkg::LABEL_MAX];
    logic [dnle_pkg::LEN_W-1:0]  label_len;
    logic [dnle_pkg::NAME_W-1:0] name_len;
    logic                        label_cut;

    task flush_label;
        int j;
        begin
            if (label_len != '0)
            begin
                wire_due.push_back({dnle_pkg::BYTE_W'(label_len), 1'b0, label_cut});
                for (j = 0; j < int'(label_len); j++)
                begin
                    wire_due.push_back({label_buf[j], 1'b0, 1'b0});
                end
                label_len = '0;
                label_cut = 1'b0;
            end
        end
    endtask

    task encode_input(input logic [dnle_pkg::BYTE_W-1:0] ch, input logic eos);
        begin
            if (eos)
            begin
                flush_label();
                wire_due.push_back({dnle_pkg::BYTE_W'(0), 1'b1, 1'b0});
                label_len = '0;
                name_len  = '0;
                label_cut = 1'b0;
            end
            else if (name_len == dnle_pkg::NAME_MAX_L)
            begin
                if (ch != dnle_pkg::DOT_CHAR)
                    label_cut = 1'b1;
            end
            else
            begin
                name_len = name_len + 1'b1;
                if (ch == dnle_pkg::DOT_CHAR)
                    flush_label();
                else if (label_len < dnle_pkg::LABEL_MAX_L)
                begin
                    label_buf[label_len] = ch;
                    label_len = label_len + 1'b1;
                end
                else
                    label_cut = 1'b1;
            end
        end
    endtask

    task check_byte(input wire_byte_t got);
        wire_byte_t want;
        begin
            if (wire_due.size() == 0)
            begin
                $error("unexpected output byte: out_byte %0d, is_last %0b, truncated %0b",
                       got.out_byte, got.is_last, got.truncated);
                fail_count++;
            end
            else
            begin
                want = wire_due.pop_front();
                if (got.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %0d, actual %0d", want.out_byte, got.out_byte);
                    fail_count++;
                end
                if (got.is_last !== want.is_last)
                begin
                    $error("is_last: expected %0b, actual %0b", want.is_last, got.is_last);
                    fail_count++;
                end
                if (got.truncated !== want.truncated)
                begin
                    $error("truncated: expected %0b, actual %0b", want.truncated,
                           got.truncated);
                    fail_count++;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wire_due.delete();
            label_len  = '0;
            name_len   = '0;
            label_cut  = 1'b0;
            fail_count = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_byte({m_axis_tdata, m_axis_tlast, m_axis_tuser[0]});
            if (s_axis_tvalid && s_axis_tready)
                encode_input(s_axis_tdata, s_axis_tlast);
        end
        pending = wire_due.size();
    end

endmodule

// File: tb/dns_name_label_encoder_test.sv
`timescale 1ns / 1ps

module dns_name_label_encoder_test;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEM_TARGET = 300;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [0:0] m_axis_tuser;

    int fail_count;
    int pending;
    int items_sent  = 0;
    int stall_left  = 0;
    int cycle_count = 0;
    bit steady      = 1'b0;

    dns_name_label_encoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    dns_name_label_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int pick_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                return 0;
            if (r < 92)
                return $urandom_range(1, 3);
            return $urandom_range(8, 40);
        end
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else if (!steady && $urandom_range(0, 4) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = pick_gap();
        end
        else
            m_axis_tready <= 1'b1;
    end

    task send_item(input logic [7:0] ch, input logic eos);
        int gap;
        begin
            gap = steady ? 0 : pick_gap();
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= ch;
            s_axis_tlast  <= eos;
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            @(negedge clk);
            items_sent++;
        end
    endtask

    task send_label(input int count);
        int k;
        logic [7:0] ch;
        begin
            for (k = 0; k < count; k++)
            begin
                ch = 8'($urandom_range(0, 255));
                if (ch == dnle_pkg::DOT_CHAR)
                    ch = ~dnle_pkg::DOT_CHAR;
                send_item(ch, 1'b0);
            end
        end
    endtask

    task send_end;
        begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    task send_noise(input int count);
        int k;
        begin
            for (k = 0; k < count; k++)
            begin
                if ($urandom_range(0, 2) == 0)
                    send_item(dnle_pkg::DOT_CHAR, 1'b0);
                else
                    send_item(8'($urandom_range(0, 255)), 1'b0);
            end
        end
    endtask

    task fill_name(input int total);
        int left;
        int len;
        begin
            left = total;
            while (left > 0)
            begin
                len = $urandom_range(1, dnle_pkg::LABEL_MAX);
                if (len > left)
                    len = left;
                send_label(len);
                left -= len;
                if (left > 0)
                begin
                    send_item(dnle_pkg::DOT_CHAR, 1'b0);
                    left--;
                end
            end
        end
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int kind;
        int n;
        int k;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(8'h00, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(dnle_pkg::DOT_CHAR, 1'b1);
        send_item(dnle_pkg::DOT_CHAR, 1'b0);
        send_item(dnle_pkg::DOT_CHAR, 1'b0);
        send_item(8'h71, 1'b0);
        send_item(dnle_pkg::DOT_CHAR, 1'b0);
        send_item(dnle_pkg::DOT_CHAR, 1'b0);
        send_item(8'h72, 1'b0);
        send_item(8'h73, 1'b0);
        send_item(dnle_pkg::DOT_CHAR, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(dnle_pkg::DOT_CHAR, 1'b0);
        send_item(dnle_pkg::DOT_CHAR, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'h55, 1'b0);
        send_item(8'hAA, 1'b0);
        send_item(dnle_pkg::DOT_CHAR, 1'b0);
        send_item(8'h00, 1'b1);

        if ($urandom_range(0, 1) == 0)
        begin
            // The name fills up on a dot, so the flag raised by later characters is lost.
            fill_name(dnle_pkg::NAME_MAX - 1);
            send_item(dnle_pkg::DOT_CHAR, 1'b0);
            send_noise($urandom_range(1, 8));
            send_end();
        end
        else
        begin
            fill_name($urandom_range(dnle_pkg::NAME_MAX - 10, dnle_pkg::NAME_MAX));
            send_label($urandom_range(11, 20));
            send_end();
        end

        while (items_sent < ITEM_TARGET)
        begin
            steady = ($urandom_range(0, 7) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 60)
            begin
                n = $urandom_range(1, 4);
                if ($urandom_range(0, 4) == 0)
                    send_item(dnle_pkg::DOT_CHAR, 1'b0);
                for (k = 0; k < n; k++)
                begin
                    send_label($urandom_range(1, 10));
                    if (k < n - 1 || $urandom_range(0, 3) == 0)
                    begin
                        send_item(dnle_pkg::DOT_CHAR, 1'b0);
                        if ($urandom_range(0, 5) == 0)
                            send_item(dnle_pkg::DOT_CHAR, 1'b0);
                    end
                end
                send_end();
            end
            else if (kind < 80)
            begin
                send_label($urandom_range(dnle_pkg::LABEL_MAX - 3, dnle_pkg::LABEL_MAX + 8));
                if ($urandom_range(0, 1) == 0)
                begin
                    send_item(dnle_pkg::DOT_CHAR, 1'b0);
                    send_label($urandom_range(1, 5));
                end
                send_end();
            end
            else
            begin
                send_noise($urandom_range(0, 20));
                send_end();
            end
        end

        s_axis_tvalid <= 1'b0;
        steady = 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (2 * dnle_pkg::LABEL_MAX + 8) @(negedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/dnle_pkg.sv
rtl/dnle_ram.sv
rtl/dns_name_label_encoder.sv
tb/dns_name_label_checker.sv
tb/dns_name_label_encoder_test.sv
